[sv/dvt_pkg.sv]
// Shared types and codes for the distinct value tracker.
`default_nettype none
package dvt_pkg;

    // Input command codes
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_SAMPLE = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    // Register index, taken from paddr[2]
    localparam logic REG_ROW_COUNT = 1'b0;

    // Depth of the queues between the parts
    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] value;
    } t_in_word;

    typedef struct packed {
        logic [16:0] distinct_now;
        logic [16:0] max_distinct;
        logic        bad_update;
    } t_out_word;

    // Classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_NOP,
        OP_ADD,
        OP_SAMPLE,
        OP_REMOVE
    } t_op_kind;

    typedef struct packed {
        t_op_kind    kind;
        logic [15:0] value;
        logic        bad;
    } t_op;

endpackage
`default_nettype wire

[sv/dvt_fifo.sv]
// Small synchronous word queue used between the parts of the tracker.
`default_nettype none
module dvt_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic      [WIDTH-1:0] o_data
);

    localparam int PW = (dvt_pkg::QDEPTH > 1) ? $clog2(dvt_pkg::QDEPTH) : 1;
    localparam int CW = $clog2(dvt_pkg::QDEPTH + 1);

    logic [WIDTH-1:0] r_mem [dvt_pkg::QDEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(dvt_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Advance pointers and track fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(dvt_pkg::QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(dvt_pkg::QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Hold words
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

[sv/dvt_front.sv]
// Front part: accepts input words, classifies them and queues operations.
`default_nettype none
module dvt_front #(
    parameter int VALUE_SPACE = 65536
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_hold,
    input  wire logic              i_push,
    input  wire dvt_pkg::t_in_word i_item,
    output logic                   o_full,
    input  wire logic              i_op_pop,
    output logic                   o_op_empty,
    output dvt_pkg::t_op           o_op
);

    dvt_pkg::t_op op_in;
    logic         q_full;
    logic         is_update;
    logic         in_range;

    // Refuse words while the back part sweeps its table
    assign o_full = q_full || i_hold;

    // Classify the incoming word
    assign is_update = ((i_item.cmd == dvt_pkg::CMD_ADD) || (i_item.cmd == dvt_pkg::CMD_REMOVE))
                       && (i_item.value != '0);
    assign in_range  = (32'(i_item.value) < 32'(VALUE_SPACE));

    always_comb begin
        op_in.value = i_item.value;
        op_in.bad   = 1'b0;
        op_in.kind  = dvt_pkg::OP_NOP;
        if (i_item.cmd == dvt_pkg::CMD_SAMPLE) begin
            op_in.kind = dvt_pkg::OP_SAMPLE;
        end else if (is_update) begin
            if (!in_range) begin
                op_in.bad = 1'b1;
            end else if (i_item.cmd == dvt_pkg::CMD_ADD) begin
                op_in.kind = dvt_pkg::OP_ADD;
            end else begin
                op_in.kind = dvt_pkg::OP_REMOVE;
            end
        end
    end

    dvt_fifo #(
        .WIDTH ($bits(dvt_pkg::t_op))
    ) u_op_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && !i_hold),
        .i_data  (op_in),
        .o_full  (q_full),
        .i_pop   (i_op_pop),
        .o_empty (o_op_empty),
        .o_data  (o_op)
    );

endmodule
`default_nettype wire

[sv/dvt_back.sv]
// Back part: histogram table, read-modify-write engine and running counts.
`default_nettype none
module dvt_back #(
    parameter int VALUE_SPACE = 65536
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [15:0]        i_row_count,
    output logic                    o_clearing,
    input  wire logic               i_op_empty,
    input  wire dvt_pkg::t_op       i_op,
    output logic                    o_op_pop,
    input  wire logic               i_res_full,
    output logic                    o_res_push,
    output dvt_pkg::t_out_word      o_res
);

    localparam int AW = (VALUE_SPACE > 1) ? $clog2(VALUE_SPACE) : 1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state       r_state;
    logic [AW-1:0] r_clr_addr;
    dvt_pkg::t_op r_op;
    logic [15:0]  r_active;
    logic [16:0]  r_nonzero;
    logic [16:0]  r_best;

    logic [15:0]  r_mem [VALUE_SPACE];
    logic [15:0]  r_rdata;

    logic [15:0]  n_active;
    logic [16:0]  n_nonzero;
    logic [16:0]  n_best;
    logic         bad;
    logic         upd_en;
    logic [15:0]  upd_data;
    logic         go;
    logic         wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]  wr_data;
    logic [16:0]  cur_distinct;

    assign o_clearing = (r_state == S_CLEAR);
    assign o_op_pop   = (r_state == S_IDLE) && !i_op_empty;
    assign go         = (r_state == S_EXEC) && !i_res_full;
    assign o_res_push = go;

    assign cur_distinct = r_nonzero + 17'((r_active < i_row_count) ? 1 : 0);

    // Work out the effect of the held operation
    always_comb begin
        n_active  = r_active;
        n_nonzero = r_nonzero;
        n_best    = r_best;
        bad       = 1'b0;
        upd_en    = 1'b0;
        upd_data  = r_rdata;
        case (r_op.kind)
            dvt_pkg::OP_ADD: begin
                if (r_active >= i_row_count) begin
                    bad = 1'b1;
                end else begin
                    upd_en   = 1'b1;
                    upd_data = r_rdata + 16'd1;
                    n_active = r_active + 16'd1;
                    if (r_rdata == '0) begin
                        n_nonzero = r_nonzero + 17'd1;
                    end
                end
            end
            dvt_pkg::OP_REMOVE: begin
                if (r_rdata == '0) begin
                    bad = 1'b1;
                end else begin
                    upd_en   = 1'b1;
                    upd_data = r_rdata - 16'd1;
                    n_active = r_active - 16'd1;
                    if (r_rdata == 16'd1) begin
                        n_nonzero = r_nonzero - 17'd1;
                    end
                end
            end
            dvt_pkg::OP_SAMPLE: begin
                if (cur_distinct > r_best) begin
                    n_best = cur_distinct;
                end
            end
            default: begin
                bad = r_op.bad;
            end
        endcase
    end

    // Build the result word
    always_comb begin
        o_res.distinct_now = n_nonzero + 17'((n_active < i_row_count) ? 1 : 0);
        o_res.max_distinct = n_best;
        o_res.bad_update   = bad;
    end

    // Select the table write: sweep during clear, update during execute
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = AW'(r_op.value);
        wr_data = upd_data;
        if (r_state == S_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else if (go && upd_en) begin
            wr_en = 1'b1;
        end
    end

    // Table write port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    // Table read port, registered
    always_ff @(posedge i_clk) begin
        if (o_op_pop) begin
            r_rdata <= r_mem[AW'(i_op.value)];
        end
    end

    // Sequencer and running counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_active   <= '0;
            r_nonzero  <= '0;
            r_best     <= 17'd1;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(VALUE_SPACE - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_op_pop) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (go) begin
                        r_active  <= n_active;
                        r_nonzero <= n_nonzero;
                        r_best    <= n_best;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Latch the operation being carried out
    always_ff @(posedge i_clk) begin
        if (o_op_pop) begin
            r_op <= i_op;
        end
    end

endmodule
`default_nettype wire

[sv/distinct_value_tracker.sv]
// Distinct value tracker: one result word per input word, in order.
// The back part reads the table, then writes it, and takes no new operation until the last
// one has gone into the result queue. At an idle block a word goes into the op queue, is
// read into the back part, then is executed into the result queue.
// Reset: synchronous, active low; the table of VALUE_SPACE entries (65536 by default) is then
// swept to zero with full held high; configuration writes are still taken.
`default_nettype none
module distinct_value_tracker #(
    parameter int VALUE_SPACE = 65536
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Input queue side
    input  wire logic              push,
    input  wire dvt_pkg::t_in_word i_item,
    output logic                   full,
    // Result queue side
    input  wire logic              pop,
    output logic                   empty,
    output dvt_pkg::t_out_word     o_result,
    // Configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic               [15:0] r_row_count;
    logic                      clearing;
    logic                      op_empty;
    logic                      op_pop;
    dvt_pkg::t_op              op;
    logic                      res_full;
    logic                      res_push;
    dvt_pkg::t_out_word        res;

    // Configuration register
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= '0;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == dvt_pkg::REG_ROW_COUNT)) begin
            r_row_count <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == dvt_pkg::REG_ROW_COUNT) ? {16'd0, r_row_count} : '0;

    dvt_front #(
        .VALUE_SPACE (VALUE_SPACE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_hold     (clearing),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .i_op_pop   (op_pop),
        .o_op_empty (op_empty),
        .o_op       (op)
    );

    dvt_back #(
        .VALUE_SPACE (VALUE_SPACE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_row_count (r_row_count),
        .o_clearing  (clearing),
        .i_op_empty  (op_empty),
        .i_op        (op),
        .o_op_pop    (op_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    dvt_fifo #(
        .WIDTH ($bits(dvt_pkg::t_out_word))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_result)
    );

endmodule
`default_nettype wire

[tb/tb_distinct_value_tracker.sv]
// Self-checking testbench for the distinct value tracker.
`timescale 1ns / 100ps
module tb_distinct_value_tracker;

    localparam int VALUE_SPACE = 65536;
    localparam int STALL_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Directed stimulus row; cfg >= 0 rewrites row_count before the row
    typedef struct {
        logic [1:0]         cmd;
        logic [15:0]        value;
        int                 cfg;
        bit                 typed;
        dvt_pkg::t_out_word want;
    } t_dir_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               push;
    dvt_pkg::t_in_word  i_item;
    logic               full;
    logic               pop;
    logic               empty;
    dvt_pkg::t_out_word o_result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // Predictor state
    bit [15:0]   hist [0:VALUE_SPACE-1];
    logic [15:0] rows_busy;
    logic [16:0] nz_values;
    logic [16:0] best_seen;
    logic [15:0] row_limit;

    dvt_pkg::t_out_word pending_results [$];
    dvt_pkg::t_out_word exp_w;
    dvt_pkg::t_out_word pred_w;
    dvt_pkg::t_out_word cur_want;
    bit          cur_typed;
    bit          hold_req;
    bit          progress;
    int          recv_stall_pct;
    int          mismatches;
    int          stalled_cycles;
    int          words_in;
    int          rejects_seen;
    int          samples_seen;
    t_dir_row    dir_rows [$];

    distinct_value_tracker dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .i_item   (i_item),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 i_clk = ~i_clk;

    // Distinct values present, zero counted while a row is idle
    function automatic logic [16:0] distinct_count();
        return nz_values + ((rows_busy < row_limit) ? 17'd1 : 17'd0);
    endfunction

    // Apply one word to the histogram and return the expected result word
    function automatic dvt_pkg::t_out_word track_word(dvt_pkg::t_in_word w);
        dvt_pkg::t_out_word r;
        logic               rej;
        rej = 1'b0;
        case (w.cmd)
            dvt_pkg::CMD_SAMPLE: begin
                if (distinct_count() > best_seen) best_seen = distinct_count();
            end
            dvt_pkg::CMD_ADD: begin
                if (w.value != 16'd0) begin
                    if (int'(w.value) >= VALUE_SPACE || rows_busy >= row_limit) begin
                        rej = 1'b1;
                    end else begin
                        if (hist[w.value] == 16'd0) nz_values = nz_values + 17'd1;
                        hist[w.value] = hist[w.value] + 16'd1;
                        rows_busy = rows_busy + 16'd1;
                    end
                end
            end
            dvt_pkg::CMD_REMOVE: begin
                if (w.value != 16'd0) begin
                    if (int'(w.value) >= VALUE_SPACE || hist[w.value] == 16'd0) begin
                        rej = 1'b1;
                    end else begin
                        hist[w.value] = hist[w.value] - 16'd1;
                        if (hist[w.value] == 16'd0) nz_values = nz_values - 17'd1;
                        rows_busy = rows_busy - 16'd1;
                    end
                end
            end
            default: ;
        endcase
        r.distinct_now = distinct_count();
        r.max_distinct = best_seen;
        r.bad_update   = rej;
        return r;
    endfunction

    // Random word: mostly updates on a small value pool, some wide values and noise
    function automatic dvt_pkg::t_in_word random_word(int pool);
        dvt_pkg::t_in_word w;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 40) w.cmd = dvt_pkg::CMD_ADD;
        else if (pick < 75) w.cmd = dvt_pkg::CMD_REMOVE;
        else if (pick < 94) w.cmd = dvt_pkg::CMD_SAMPLE;
        else w.cmd = CMD_UNUSED;
        pick = $urandom_range(99);
        if (pick < 5) w.value = 16'd0;
        else if (pick < 8) w.value = 16'hFFFF;
        else if (pick < 85) w.value = 16'($urandom_range(pool, 1));
        else w.value = 16'($urandom_range(65535, 1));
        return w;
    endfunction

    // Scoreboard and watchdog: check results, then record accepted words
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            progress = 1'b0;
            if (pop && !empty) begin
                progress = 1'b1;
                if (pending_results.size() == 0) begin
                    $error("result word with nothing expected: %h", o_result);
                    mismatches++;
                end else begin
                    exp_w = pending_results.pop_front();
                    if (o_result.distinct_now !== exp_w.distinct_now) begin
                        $error("distinct_now: expected %0d, got %0d",
                               exp_w.distinct_now, o_result.distinct_now);
                        mismatches++;
                    end
                    if (o_result.max_distinct !== exp_w.max_distinct) begin
                        $error("max_distinct: expected %0d, got %0d",
                               exp_w.max_distinct, o_result.max_distinct);
                        mismatches++;
                    end
                    if (o_result.bad_update !== exp_w.bad_update) begin
                        $error("bad_update: expected %0d, got %0d",
                               exp_w.bad_update, o_result.bad_update);
                        mismatches++;
                    end
                end
            end
            if (push && !full) begin
                progress = 1'b1;
                pred_w = track_word(i_item);
                pending_results.push_back(cur_typed ? cur_want : pred_w);
                words_in++;
                if (pred_w.bad_update) rejects_seen++;
                if (i_item.cmd == dvt_pkg::CMD_SAMPLE) samples_seen++;
            end
            if (psel && penable && pready) progress = 1'b1;
            stalled_cycles <= progress ? 0 : stalled_cycles + 1;
            if (stalled_cycles >= STALL_LIMIT) begin
                $display("no progress for %0d cycles", STALL_LIMIT);
                $display("distinct_value_tracker regression: fail");
                $finish;
            end
        end
    end

    // Result side: random stalls, plus a long hold-off on request
    initial begin
        pop <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) begin
                    pop <= 1'b0;
                    @(negedge i_clk);
                end
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one word after a random gap; return at the falling edge after acceptance
    task automatic send_word(dvt_pkg::t_in_word w, bit typed, dvt_pkg::t_out_word want,
                             int send_pct);
        while ($urandom_range(99) < send_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        cur_typed = typed;
        cur_want  = want;
        push   <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    // Drop push and wait until every expected word has come back
    task automatic drain();
        push <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    // Write row_count, then read it back
    task automatic write_rows(logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {dvt_pkg::REG_ROW_COUNT, 2'b00};
        pwdata  <= {16'd0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        row_limit = v;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {16'd0, v}) begin
            $error("row_count readback: expected %0d, got %0d", v, prdata);
            mismatches++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_phase(int rows, int send_pct, int recv_pct, int n, int pool,
                             bit pressure);
        dvt_pkg::t_out_word none;
        none = '0;
        drain();
        write_rows(16'(rows));
        recv_stall_pct = recv_pct;
        if (pressure) hold_req = 1'b1;
        repeat (n) send_word(random_word(pool), 1'b0, none, send_pct);
    endtask

    task automatic add_row(logic [1:0] c, logic [15:0] v, int cfg, bit typed,
                           int dn, int md, bit bad);
        t_dir_row r;
        r.cmd   = c;
        r.value = v;
        r.cfg   = cfg;
        r.typed = typed;
        r.want.distinct_now = 17'(dn);
        r.want.max_distinct = 17'(md);
        r.want.bad_update   = bad;
        dir_rows.push_back(r);
    endtask

    initial begin
        dvt_pkg::t_in_word w;
        push     <= 1'b0;
        i_item   <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        i_rst_n  <= 1'b0;
        hold_req = 1'b0;
        recv_stall_pct = 0;
        mismatches = 0;
        stalled_cycles = 0;
        words_in = 0;
        rejects_seen = 0;
        samples_seen = 0;
        cur_typed = 1'b0;
        rows_busy = '0;
        nz_values = '0;
        best_seen = 17'd1;
        row_limit = '0;

        // After reset with no rows: nothing present, every add of a nonzero value rejected
        add_row(dvt_pkg::CMD_SAMPLE, 16'h0000, -1, 1, 0, 1, 0);
        add_row(dvt_pkg::CMD_ADD,    16'hFFFF, -1, 1, 0, 1, 1);
        add_row(dvt_pkg::CMD_ADD,    16'h0000, -1, 1, 0, 1, 0);
        add_row(dvt_pkg::CMD_REMOVE, 16'h0001, -1, 1, 0, 1, 1);
        add_row(dvt_pkg::CMD_REMOVE, 16'h0000, -1, 1, 0, 1, 0);
        add_row(CMD_UNUSED,          16'hAAAA, -1, 1, 0, 1, 0);
        add_row(dvt_pkg::CMD_SAMPLE, 16'h5555, -1, 1, 0, 1, 0);
        // Three rows: fill, overflow, duplicate values, remove to absent
        add_row(dvt_pkg::CMD_ADD,    16'h0001,  3, 0, 0, 0, 0);
        add_row(dvt_pkg::CMD_ADD,    16'h0001, -1, 0, 0, 0, 0);
        add_row(dvt_pkg::CMD_SAMPLE, 16'h0000, -1, 0, 0, 0, 0);
        add_row(dvt_pkg::CMD_ADD,    16'hFFFF, -1, 0, 0, 0, 0);
        add_row(dvt_pkg::CMD_ADD,    16'h0002, -1, 0, 0, 0, 0);
        add_row(dvt_pkg::CMD_SAMPLE, 16'h0000, -1, 0, 0, 0, 0);
        add_row(dvt_pkg::CMD_REMOVE, 16'hFFFF, -1, 0, 0, 0, 0);
        add_row(dvt_pkg::CMD_REMOVE, 16'h0001, -1, 0, 0, 0, 0);
        add_row(dvt_pkg::CMD_REMOVE, 16'h0001, -1, 0, 0, 0, 0);
        add_row(dvt_pkg::CMD_REMOVE, 16'h0001, -1, 0, 0, 0, 0);
        add_row(dvt_pkg::CMD_ADD,    16'h8000, -1, 0, 0, 0, 0);
        add_row(dvt_pkg::CMD_ADD,    16'h7FFF, -1, 0, 0, 0, 0);
        // Row count lowered below the busy rows
        add_row(dvt_pkg::CMD_SAMPLE, 16'h0000,  1, 0, 0, 0, 0);
        add_row(dvt_pkg::CMD_ADD,    16'h0004, -1, 0, 0, 0, 0);
        add_row(dvt_pkg::CMD_REMOVE, 16'h8000, -1, 0, 0, 0, 0);
        add_row(dvt_pkg::CMD_SAMPLE, 16'h0000, -1, 0, 0, 0, 0);
        add_row(dvt_pkg::CMD_REMOVE, 16'h7FFF, -1, 0, 0, 0, 0);
        add_row(dvt_pkg::CMD_SAMPLE, 16'h0000, -1, 0, 0, 0, 0);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part
        foreach (dir_rows[k]) begin
            if (dir_rows[k].cfg >= 0) begin
                drain();
                write_rows(16'(dir_rows[k].cfg));
            end
            w.cmd   = dir_rows[k].cmd;
            w.value = dir_rows[k].value;
            send_word(w, dir_rows[k].typed, dir_rows[k].want, 0);
        end

        // Random part across rate phases; the largest row count and value pool go last
        run_phase(6,     0,  0,  250, 8,   0);
        run_phase(3,     55, 0,  250, 5,   0);
        run_phase(2,     0,  55, 200, 6,   0);
        run_phase(12,    17, 17, 250, 16,  0);
        run_phase(0,     0,  0,  150, 10,  1);
        run_phase(65535, 17, 17, 300, 400, 0);

        drain();
        repeat (10) @(posedge i_clk);
        $display("covered %0d words: %0d rejected updates, %0d samples, peak distinct %0d",
                 words_in, rejects_seen, samples_seen, best_seen);
        $display("row counts 0 to 65535, idle and stall mixes, one long result hold-off");
        if (mismatches == 0) begin
            $display("distinct_value_tracker regression: pass");
        end else begin
            $display("distinct_value_tracker regression: fail");
        end
        $finish;
    end

endmodule

[sim.f]
sv/dvt_pkg.sv
sv/dvt_fifo.sv
sv/dvt_front.sv
sv/dvt_back.sv
sv/distinct_value_tracker.sv
tb/tb_distinct_value_tracker.sv
